/* hw/rtl/lppd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types, constants and the arctangent step table of the lidar
// packet point decoder.
// ----------------------------------------------------------------------------
package lppd_pkg;

    // stream framing
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;

    // angle units of 1/64 degree
    localparam logic [14:0] TURN64 = 15'd23040;
    localparam logic [15:0] HALF64 = 16'd11520;
    // two turns in 1/16384 degree, keeps the angle sum positive
    localparam logic signed [31:0] TURN_BIAS = 32'sd11796480;
    localparam logic signed [31:0] ROUND_HALF = 32'sd128;

    // iterative units
    localparam int DIV_STEPS    = 31;
    localparam int CORDIC_STEPS = 18;

    // configuration register indexes
    localparam logic [7:0] CFG_CROP_ENABLE = 8'd0;
    localparam logic [7:0] CFG_CROP_LOW    = 8'd1;
    localparam logic [7:0] CFG_CROP_HIGH   = 8'd2;
    localparam logic [7:0] CFG_MIN_DIST    = 8'd3;

    typedef struct packed {
        logic        crop_enable;
        logic [14:0] crop_low_angle;
        logic [14:0] crop_high_angle;
        logic [15:0] min_distance;
    } t_cfg;

    // one point job handed from the parser to the math unit
    typedef struct packed {
        logic [15:0]        raw;
        logic [14:0]        start64;
        logic signed [15:0] span;
        logic [7:0]         num;
        logic [7:0]         cnt;
    } t_job;

    // atan(2^-i) in 1/16384 degree, rounded
    function automatic logic signed [23:0] f_atan(input logic [4:0] i);
        logic signed [23:0] v;
        v = '0;
        case (i)
            5'd0:    v = 24'sd737280;
            5'd1:    v = 24'sd435242;
            5'd2:    v = 24'sd229970;
            5'd3:    v = 24'sd116736;
            5'd4:    v = 24'sd58595;
            5'd5:    v = 24'sd29326;
            5'd6:    v = 24'sd14667;
            5'd7:    v = 24'sd7334;
            5'd8:    v = 24'sd3667;
            5'd9:    v = 24'sd1833;
            5'd10:   v = 24'sd917;
            5'd11:   v = 24'sd458;
            5'd12:   v = 24'sd229;
            5'd13:   v = 24'sd115;
            5'd14:   v = 24'sd57;
            5'd15:   v = 24'sd29;
            5'd16:   v = 24'sd14;
            5'd17:   v = 24'sd7;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/lppd_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lppd channel interfaces
// Byte input, point output and configuration write channels.
// ----------------------------------------------------------------------------
interface lppd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lppd_point_if;
    logic        valid;
    logic        ready;
    logic [14:0] point_angle;
    logic [15:0] point_distance;
    logic        in_sector;
    logic        new_scan;
    logic        before_first_scan;
    modport source (output valid, output point_angle, output point_distance,
                    output in_sector, output new_scan, output before_first_scan,
                    input ready);
    modport sink   (input valid, input point_angle, input point_distance,
                    input in_sector, input new_scan, input before_first_scan,
                    output ready);
endinterface

interface lppd_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lppd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lppd_front
// Packet parser: header sync, header fields, angle span and point jobs.
// ----------------------------------------------------------------------------
module lppd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_acc,
    input  wire logic [7:0]    i_byte,
    input  wire lppd_pkg::t_cfg i_cfg,
    output lppd_pkg::t_job     o_job,
    output logic               o_push
);

    typedef enum logic [1:0] {PH_HDR1, PH_HDR2, PH_PRE, PH_BODY} t_phase;

    t_phase r_phase, n_phase;
    logic [9:0] r_pos, n_pos;
    logic [7:0] r_cnt, n_cnt;
    logic [15:0] r_start, n_start;
    logic signed [15:0] r_span, n_span;
    logic [7:0] r_dlow, n_dlow;
    logic [7:0] r_num, n_num;
    logic [1:0] r_k, n_k;

    logic [9:0] w_last_pos;
    logic [15:0] w_word;
    logic signed [16:0] w_diff;
    logic signed [16:0] w_span;

    // last byte position of the packet
    assign w_last_pos = ({2'b0, r_cnt} << 1) + {2'b0, r_cnt} + 10'd7;
    assign w_word = {i_byte, r_dlow};

    // span from start to end angle, one turn added when negative, zero for cnt <= 1
    always_comb begin
        w_diff = $signed({2'b0, w_word[15:1]}) - $signed({2'b0, r_start[15:1]});
        w_span = w_diff;
        if (w_diff < 0) begin
            w_span = w_diff + $signed({2'b0, lppd_pkg::TURN64});
        end
        if (r_cnt <= 8'd1) begin
            w_span = '0;
        end
    end

    // job payload
    assign o_job.raw     = w_word;
    assign o_job.start64 = r_start[15:1];
    assign o_job.span    = r_span;
    assign o_job.num     = r_num;
    assign o_job.cnt     = r_cnt;

    // parser next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_start = r_start;
        n_span  = r_span;
        n_dlow  = r_dlow;
        n_num   = r_num;
        n_k     = r_k;
        o_push  = 1'b0;
        if (i_acc) begin
            unique case (r_phase)
                PH_HDR1: begin
                    if (i_byte == lppd_pkg::HDR_FIRST) begin
                        n_phase = PH_HDR2;
                        n_pos   = 10'd1;
                    end
                end
                PH_HDR2: begin
                    if (i_byte == lppd_pkg::HDR_SECOND) begin
                        n_phase = PH_PRE;
                        n_pos   = 10'd2;
                    end else if (i_byte == lppd_pkg::HDR_FIRST) begin
                        n_pos = 10'd1;
                    end else begin
                        n_phase = PH_HDR1;
                        n_pos   = 10'd0;
                    end
                end
                PH_PRE: begin
                    if (r_pos >= 10'd3) begin
                        n_cnt   = i_byte;
                        n_num   = 8'd0;
                        n_phase = PH_BODY;
                    end
                    n_pos = r_pos + 10'd1;
                end
                PH_BODY: begin
                    if (r_pos == 10'd4) begin
                        n_start[7:0] = i_byte;
                    end else if (r_pos == 10'd5) begin
                        n_start[15:8] = i_byte;
                    end else if (r_pos == 10'd6) begin
                        n_dlow = i_byte;
                    end else if (r_pos == 10'd7) begin
                        n_span = w_span[15:0];
                        n_k    = 2'd0;
                    end else begin
                        // sample bytes: distance low, distance high, ignored
                        if (r_k == 2'd0) begin
                            n_dlow = i_byte;
                            n_k    = 2'd1;
                        end else if (r_k == 2'd1) begin
                            o_push = (w_word > i_cfg.min_distance);
                            n_k    = 2'd2;
                        end else begin
                            n_num = r_num + 8'd1;
                            n_k   = 2'd0;
                        end
                    end
                    if (r_pos >= w_last_pos) begin
                        n_phase = PH_HDR1;
                        n_pos   = 10'd0;
                    end else begin
                        n_pos = r_pos + 10'd1;
                    end
                end
                default: begin
                    n_phase = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR1;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_start <= '0;
            r_span  <= '0;
            r_dlow  <= '0;
            r_num   <= '0;
            r_k     <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_start <= n_start;
            r_span  <= n_span;
            r_dlow  <= n_dlow;
            r_num   <= n_num;
            r_k     <= n_k;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lppd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lppd_queue
// Two-entry job queue between the parser and the math unit.
// ----------------------------------------------------------------------------
module lppd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lppd_pkg::t_job i_job,
    input  wire logic           i_pop,
    output lppd_pkg::t_job      o_job,
    output logic                o_full,
    output logic                o_empty
);

    lppd_pkg::t_job r_mem [2];
    logic r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/lppd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lppd_back
// Point math: interpolation divider, CORDIC correction, wrap, flags and
// the output register.
// ----------------------------------------------------------------------------
module lppd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lppd_pkg::t_job i_job,
    input  wire logic           i_empty,
    input  wire lppd_pkg::t_cfg i_cfg,
    output logic                o_pop,
    lppd_point_if.source        o_point
);

    typedef enum logic [2:0] {ST_IDLE, ST_LOAD, ST_CALC, ST_SUM, ST_WRAP} t_state;

    t_state r_state;
    lppd_pkg::t_job r_job;
    logic [4:0] r_step;
    logic [30:0] r_dvd;
    logic [7:0] r_rem;
    logic [7:0] r_div;
    logic r_neg;
    logic signed [51:0] r_x, r_y;
    logic signed [23:0] r_z;
    logic [16:0] r_v;
    logic [14:0] r_last;
    logic r_wrap_seen;

    logic r_out_valid;
    logic [14:0] r_out_angle;
    logic [15:0] r_out_dist;
    logic r_out_ins, r_out_ns, r_out_bfs;

    logic w_out_free;
    logic w_out_load;
    logic signed [24:0] w_prod;
    logic [22:0] w_mag;
    logic [28:0] w_xm;
    logic [19:0] w_raw10;
    logic signed [21:0] w_ydiff;
    logic signed [28:0] w_ym;
    logic [8:0] w_rem_sh;
    logic w_qbit;
    logic signed [51:0] w_xs, w_ys;
    logic signed [31:0] w_quot, w_t;
    logic [14:0] w_a;
    logic w_ns, w_ins;

    assign w_out_free = !r_out_valid || o_point.ready;
    assign o_pop = (r_state == ST_IDLE) && !i_empty;
    // finished point moves into the output register
    assign w_out_load = (r_state == ST_WRAP) && (r_v < {2'b0, lppd_pkg::TURN64})
                        && w_out_free;

    // setup products
    assign w_prod  = r_job.span * $signed({1'b0, r_job.num});
    assign w_mag   = w_prod[24] ? 23'(-w_prod) : w_prod[22:0];
    assign w_xm    = 29'(r_job.raw) * 29'd7765;
    assign w_raw10 = ({4'b0, r_job.raw} << 3) + ({4'b0, r_job.raw} << 1);
    assign w_ydiff = 22'sd6212 - $signed({2'b0, w_raw10});
    assign w_ym    = 29'(w_ydiff) * 29'sd109;

    // divider step
    assign w_rem_sh = {r_rem, r_dvd[30]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_div});

    // cordic shifts
    assign w_xs = r_x >>> r_step;
    assign w_ys = r_y >>> r_step;

    // angle sum
    always_comb begin
        w_quot = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
        if (r_job.cnt <= 8'd1) begin
            w_quot = '0;
        end
        w_t = $signed({9'b0, r_job.start64, 8'b0}) + w_quot
            + $signed({{8{r_z[23]}}, r_z}) + lppd_pkg::ROUND_HALF + lppd_pkg::TURN_BIAS;
    end

    // flags of the finished point
    assign w_a  = r_v[14:0];
    assign w_ns = (({1'b0, w_a} + lppd_pkg::HALF64) < {1'b0, r_last});
    always_comb begin
        if (!i_cfg.crop_enable) begin
            w_ins = 1'b1;
        end else if (i_cfg.crop_low_angle > i_cfg.crop_high_angle) begin
            w_ins = (w_a >= i_cfg.crop_low_angle) || (w_a <= i_cfg.crop_high_angle);
        end else begin
            w_ins = (w_a >= i_cfg.crop_low_angle) && (w_a <= i_cfg.crop_high_angle);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last      <= '0;
            r_wrap_seen <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_point.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_dvd   <= {w_mag, 8'b0};
                    r_neg   <= w_prod[24];
                    r_rem   <= '0;
                    r_div   <= r_job.cnt - 8'd1;
                    r_x     <= {7'b0, w_xm, 16'b0};
                    r_y     <= {{7{w_ym[28]}}, w_ym, 16'b0};
                    r_z     <= '0;
                    r_step  <= '0;
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    // one restoring division step
                    r_rem <= w_qbit ? 8'(w_rem_sh - {1'b0, r_div}) : w_rem_sh[7:0];
                    r_dvd <= {r_dvd[29:0], w_qbit};
                    // one cordic vectoring step in parallel
                    if (32'(r_step) < lppd_pkg::CORDIC_STEPS) begin
                        if (r_y >= 0) begin
                            r_x <= r_x + w_ys;
                            r_y <= r_y - w_xs;
                            r_z <= r_z + lppd_pkg::f_atan(r_step);
                        end else begin
                            r_x <= r_x - w_ys;
                            r_y <= r_y + w_xs;
                            r_z <= r_z - lppd_pkg::f_atan(r_step);
                        end
                    end
                    if (32'(r_step) == lppd_pkg::DIV_STEPS - 1) begin
                        r_state <= ST_SUM;
                    end
                    r_step <= r_step + 5'd1;
                end
                ST_SUM: begin
                    r_v     <= w_t[24:8];
                    r_state <= ST_WRAP;
                end
                ST_WRAP: begin
                    if (r_v >= {2'b0, lppd_pkg::TURN64}) begin
                        r_v <= r_v - {2'b0, lppd_pkg::TURN64};
                    end else if (w_out_free) begin
                        r_out_angle <= w_a;
                        r_out_dist  <= r_job.raw;
                        r_out_ins   <= w_ins;
                        r_out_ns    <= w_ns;
                        r_out_bfs   <= !(r_wrap_seen || w_ns);
                        r_last      <= w_a;
                        if (w_ns) begin
                            r_wrap_seen <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_point.valid             = r_out_valid;
    assign o_point.point_angle       = r_out_angle;
    assign o_point.point_distance    = r_out_dist;
    assign o_point.in_sector         = r_out_ins;
    assign o_point.new_scan          = r_out_ns;
    assign o_point.before_first_scan = r_out_bfs;

endmodule
`default_nettype wire

/* hw/rtl/lidar_packet_point_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_packet_point_decoder_unit
// Lidar scan packet decoder: serial bytes in, corrected points out.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle while its two-entry point queue has
// room. Each point above the distance threshold then passes through the math
// unit: a load step, 31 restoring divider steps for the angle interpolation
// (the 18 CORDIC correction steps run alongside), a sum step, turn wrapping
// and the handoff into the output register. A point needs three bytes and the
// math unit takes one point at a time; once the queue is full, the byte
// channel stalls. Configuration writes are taken at once, in every cycle.
module lidar_packet_point_decoder_unit (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lppd_byte_if.sink    i_byte,
    lppd_cfg_if.sink     i_cfg,
    lppd_point_if.source o_point
);

    lppd_pkg::t_cfg r_cfg;
    lppd_pkg::t_job w_push_job, w_pop_job;
    logic w_push, w_pop, w_full, w_empty, w_acc;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = !w_full;
    assign w_acc        = i_byte.valid && i_byte.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crop_enable     <= 1'b1;
            r_cfg.crop_low_angle  <= 15'd17280;
            r_cfg.crop_high_angle <= 15'd5760;
            r_cfg.min_distance    <= 16'd40;
        end else if (i_cfg.valid) begin
            priority if (i_cfg.index == lppd_pkg::CFG_CROP_ENABLE) begin
                r_cfg.crop_enable <= i_cfg.data[0];
            end else if (i_cfg.index == lppd_pkg::CFG_CROP_LOW) begin
                r_cfg.crop_low_angle <= i_cfg.data[14:0];
            end else if (i_cfg.index == lppd_pkg::CFG_CROP_HIGH) begin
                r_cfg.crop_high_angle <= i_cfg.data[14:0];
            end else if (i_cfg.index == lppd_pkg::CFG_MIN_DIST) begin
                r_cfg.min_distance <= i_cfg.data;
            end else begin
                r_cfg <= r_cfg;
            end
        end
    end

    lppd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_byte  (i_byte.rx_byte),
        .i_cfg   (r_cfg),
        .o_job   (w_push_job),
        .o_push  (w_push)
    );

    lppd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lppd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_pop_job),
        .i_empty (w_empty),
        .i_cfg   (r_cfg),
        .o_pop   (w_pop),
        .o_point (o_point)
    );

    // a job never lands on a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("point job pushed into a full queue");

    // a new revolution point is never before the first wrap
    a_wrap_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point.valid && o_point.new_scan) |-> !o_point.before_first_scan)
        else $error("new scan flagged before first scan");

    // angle stays within one turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point.valid |-> (o_point.point_angle < lppd_pkg::TURN64))
        else $error("point angle outside one turn");

endmodule
`default_nettype wire

/* verif/lppd_point_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_point_checker
// Watches the byte, configuration and point channels of the lidar packet
// point decoder, predicts every point from the byte stream and compares each
// transferred point with the oldest predicted one.
// ----------------------------------------------------------------------------
module lppd_point_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lppd_byte_if      i_byte,
    lppd_cfg_if       i_cfg,
    lppd_point_if     i_point,
    output int        o_errors,
    output int        o_pending,
    output int        o_points
);

    typedef struct packed {
        logic [14:0] angle;
        logic [15:0] range_raw;
        logic        in_sector;
        logic        new_scan;
        logic        before_first;
    } t_point;

    localparam int  ANGLE_TURN = 23040;
    localparam int  ANGLE_HALF = 11520;
    localparam int  CORR_STEPS = 18;
    localparam longint CORR_ATAN [CORR_STEPS] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334, 3667,
        1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    // copy of the registers
    logic        crop_on;
    logic [14:0] crop_lo;
    logic [14:0] crop_hi;
    logic [15:0] dist_floor;

    // copy of the parser state
    logic [1:0]  hdr_phase;
    logic [9:0]  pkt_pos;
    logic [7:0]  pkt_count;
    logic [15:0] start_word;
    int          pkt_span;
    logic [7:0]  dist_low;
    logic [7:0]  sample_idx;
    logic [14:0] prev_angle;
    logic        wrapped;

    t_point      expected_points [$];

    // arctangent triangulation correction, 1/16384 degree
    function automatic longint triangulation_offset(input logic [15:0] raw);
        longint r, x, y, z, xs, ys;
        r = longint'(raw);
        x = 64'sd7765 * r * 64'sd65536;
        y = 64'sd109 * (64'sd6212 - 64'sd10 * r) * 64'sd65536;
        z = 0;
        for (int i = 0; i < CORR_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + CORR_ATAN[i];
            end else begin
                x = x - ys; y = y + xs; z = z - CORR_ATAN[i];
            end
        end
        return z;
    endfunction

    // advance the parser copy by one byte, report a point if one is due
    function automatic bit decode_byte(input logic [7:0] b, output t_point pt);
        logic [9:0]  p;
        logic [15:0] raw;
        int          s64, e64, span, k, a;
        longint      interp, t;
        bit          hit;
        p   = pkt_pos;
        hit = 0;
        pt  = '0;
        if (hdr_phase == 2'd0) begin
            if (b == lppd_pkg::HDR_FIRST) begin hdr_phase = 2'd1; pkt_pos = 10'd1; end
            return 0;
        end
        if (hdr_phase == 2'd1) begin
            if (b == lppd_pkg::HDR_SECOND) begin
                hdr_phase = 2'd2; pkt_pos = 10'd2;
            end else if (b == lppd_pkg::HDR_FIRST) begin
                pkt_pos = 10'd1;
            end else begin
                hdr_phase = 2'd0; pkt_pos = 10'd0;
            end
            return 0;
        end
        if (hdr_phase == 2'd2) begin
            if (p >= 3) begin
                pkt_count = b; sample_idx = 8'd0; hdr_phase = 2'd3;
            end
            pkt_pos = p + 10'd1;
            return 0;
        end
        if (p == 4) begin
            start_word = {8'd0, b};
        end else if (p == 5) begin
            start_word = {b, start_word[7:0]};
        end else if (p == 6) begin
            dist_low = b;
        end else if (p == 7) begin
            s64  = int'(start_word >> 1);
            e64  = int'({b, dist_low} >> 1);
            span = 0;
            if (pkt_count > 1) begin
                span = e64 - s64;
                if (span < 0) span += ANGLE_TURN;
            end
            pkt_span = span;
        end else if (p >= 8) begin
            k = (int'(p) - 8) % 3;
            if (k == 0) begin
                dist_low = b;
            end else if (k == 1) begin
                raw = {b, dist_low};
                if (raw > dist_floor) begin
                    interp = longint'(start_word >> 1) * 256;
                    if (pkt_count > 1)
                        interp += (longint'(pkt_span) * 256 * longint'(sample_idx))
                                  / longint'(pkt_count - 1);
                    t = interp + triangulation_offset(raw) + 128
                        + 64'sd2 * ANGLE_TURN * 256;
                    if (t < 0) t = 0;
                    a = int'((t >> 8) % ANGLE_TURN);
                    pt.new_scan = 1'b0;
                    if (a + ANGLE_HALF < int'(prev_angle)) begin
                        pt.new_scan = 1'b1; wrapped = 1'b1;
                    end
                    prev_angle = a[14:0];
                    if (!crop_on)
                        pt.in_sector = 1'b1;
                    else if (crop_lo > crop_hi)
                        pt.in_sector = (a >= crop_lo || a <= crop_hi);
                    else
                        pt.in_sector = (a >= crop_lo && a <= crop_hi);
                    pt.angle        = a[14:0];
                    pt.range_raw    = raw;
                    pt.before_first = !wrapped;
                    hit = 1;
                end
            end else begin
                sample_idx = sample_idx + 8'd1;
            end
        end
        if (int'(p) >= 7 + 3 * int'(pkt_count)) begin
            hdr_phase = 2'd0; pkt_pos = 10'd0;
        end else begin
            pkt_pos = p + 10'd1;
        end
        return hit;
    endfunction

    // channel monitor: compare outgoing points, track register writes, then predict from incoming bytes
    always @(posedge i_clk) begin
        t_point got, want, fresh;
        if (!i_rst_n) begin
            crop_on = 1'b1; crop_lo = 15'd17280; crop_hi = 15'd5760;
            dist_floor = 16'd40;
            hdr_phase = '0; pkt_pos = '0; pkt_count = '0; start_word = '0;
            pkt_span = 0; dist_low = '0; sample_idx = '0; prev_angle = '0;
            wrapped = 1'b0;
            expected_points.delete();
            o_errors = 0; o_points = 0;
        end else begin
            if (i_point.valid && i_point.ready) begin
                got = '{i_point.point_angle, i_point.point_distance,
                        i_point.in_sector, i_point.new_scan,
                        i_point.before_first_scan};
                o_points++;
                if (expected_points.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected point: angle %0d dist %0d",
                                 got.angle, got.range_raw);
                end else begin
                    want = expected_points.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"point mismatch: exp ang %0d dist %0d sec %0b ",
                                      "new %0b pre %0b / got ang %0d dist %0d sec %0b ",
                                      "new %0b pre %0b"},
                                     want.angle, want.range_raw, want.in_sector,
                                     want.new_scan, want.before_first,
                                     got.angle, got.range_raw, got.in_sector,
                                     got.new_scan, got.before_first);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    lppd_pkg::CFG_CROP_ENABLE: crop_on    = i_cfg.data[0];
                    lppd_pkg::CFG_CROP_LOW:    crop_lo    = i_cfg.data[14:0];
                    lppd_pkg::CFG_CROP_HIGH:   crop_hi    = i_cfg.data[14:0];
                    lppd_pkg::CFG_MIN_DIST:    dist_floor = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_byte.valid && i_byte.ready) begin
                if (decode_byte(i_byte.rx_byte, fresh))
                    expected_points.insert(expected_points.size(), fresh);
            end
        end
        o_pending = expected_points.size();
    end

endmodule

/* verif/lidar_packet_point_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_packet_point_decoder_unit_tb
// Feeds directed and random lidar packets, noise and broken headers through
// the decoder under several register settings and flow-control patterns;
// the checker predicts and compares every point.
// ----------------------------------------------------------------------------
module lidar_packet_point_decoder_unit_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 64;
    localparam int PHASES      = 8;
    localparam int PHASE_BYTES = 145;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, points;
    int   cycles;
    int   bytes_sent;
    int   send_idle_pct, recv_stall_pct;

    lppd_byte_if  byte_ch ();
    lppd_cfg_if   cfg_ch ();
    lppd_point_if point_ch ();

    lidar_packet_point_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .i_cfg   (cfg_ch),
        .o_point (point_ch)
    );

    lppd_point_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (byte_ch),
        .i_cfg     (cfg_ch),
        .i_point   (point_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_points  (points)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver flow control
    always @(posedge i_clk) begin
        point_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_points();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic send_packet(input logic [7:0] cnt, input logic [15:0] sw,
                               input logic [15:0] ew, input logic [15:0] floor_d);
        logic [15:0] d;
        int          r, near;
        send_byte(lppd_pkg::HDR_FIRST);
        send_byte(lppd_pkg::HDR_SECOND);
        send_byte(8'($urandom_range(255)));
        send_byte(cnt);
        send_byte(sw[7:0]);
        send_byte(sw[15:8]);
        send_byte(ew[7:0]);
        send_byte(ew[15:8]);
        for (int i = 0; i < cnt; i++) begin
            r = $urandom_range(99);
            if (r < 20) begin
                near = int'(floor_d) + int'($urandom_range(2)) - 1;
                if (near < 0) near = 0;
                if (near > 65535) near = 65535;
                d = near[15:0];
            end else if (r < 25) begin
                d = 16'hFFFF;
            end else if (r < 30) begin
                d = 16'($urandom_range(255));
            end else if (r < 35) begin
                d = {lppd_pkg::HDR_FIRST, lppd_pkg::HDR_FIRST};
            end else begin
                d = 16'($urandom_range(65535));
            end
            send_byte(d[7:0]);
            send_byte(d[15:8]);
            send_byte(($urandom_range(9) == 0) ? lppd_pkg::HDR_FIRST
                                               : 8'($urandom_range(255)));
        end
    endtask

    function automatic logic [15:0] pick_angle_word();
        if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
        return 16'($urandom_range(46079));
    endfunction

    initial begin
        logic [15:0] floor_d, lo, hi;
        int          r, n;
        cycles = 0; bytes_sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        byte_ch.valid = 1'b0; byte_ch.rx_byte = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        point_ch.ready = 1'b1;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: repeated first header byte, broken header, empty packet
        send_byte(lppd_pkg::HDR_FIRST); send_byte(lppd_pkg::HDR_FIRST); send_byte(8'h00);
        send_packet(8'd0, 16'd0, 16'd0, 16'd40);
        // single sample, start word beyond one turn
        send_packet(8'd1, 16'hFFFF, 16'h0000, 16'd40);
        // three samples, span across zero angle; header bytes in data and threshold edge only by chance
        send_packet(8'd3, 16'd46078, 16'd2, 16'd40);
        drain_points();

        floor_d = 16'd40;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            // register settings per phase, extremes among them
            case (ph)
                0: begin lo = 16'd17280; hi = 16'd5760;  floor_d = 16'd40; end
                1: begin lo = 16'd0;     hi = 16'd23039; floor_d = 16'd0;  end
                2: begin lo = 16'd23039; hi = 16'd0;     floor_d = 16'd200; end
                3: begin lo = 16'hFFFF;  hi = 16'h7FFF;  floor_d = 16'd65535; end
                default: begin
                    lo = 16'($urandom_range(65535)); hi = 16'($urandom_range(65535));
                    floor_d = 16'($urandom_range(3000));
                end
            endcase
            cfg_write(lppd_pkg::CFG_CROP_ENABLE,
                      (ph == 1) ? 16'hFFFE : 16'($urandom_range(65535) | 1));
            cfg_write(lppd_pkg::CFG_CROP_LOW, lo);
            cfg_write(lppd_pkg::CFG_CROP_HIGH, hi);
            cfg_write(lppd_pkg::CFG_MIN_DIST, floor_d);
            cfg_write(8'd4 + 8'($urandom_range(250)), 16'($urandom_range(65535)));

            n = bytes_sent + PHASE_BYTES;
            while (bytes_sent < n) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
                end else if (r < 12) begin
                    send_byte(lppd_pkg::HDR_FIRST); send_byte(lppd_pkg::HDR_FIRST);
                end else if (r < 15) begin
                    send_byte(lppd_pkg::HDR_FIRST); send_byte(8'($urandom_range(255)));
                end
                r = $urandom_range(99);
                send_packet((r < 5) ? 8'd0 : (r < 90) ? 8'($urandom_range(10, 1))
                                                      : 8'($urandom_range(40, 11)),
                            pick_angle_word(), pick_angle_word(), floor_d);
            end
            // sender holds off until every predicted point is out
            drain_points();
        end

        $display("covered %0d bytes and %0d points over %0d register settings",
                 bytes_sent, points, PHASES);
        $display("flow control: free, sender gaps, receiver stalls, mixed");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
